### rtl/core/sacp_pkg.sv
// Package with the payload types and constants of the short command APDU parser.
`default_nettype none

package sacp_pkg;

  // Width of the saturating byte counter.
  localparam int unsigned CountWidth = 9;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Limit register width and its reset value.
  localparam int unsigned LimitWidth = 9;
  localparam logic [LimitWidth-1:0] LimitReset = 9'd256;

  // Result queue: it must hold two results from one byte.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

  // Byte positions within a command block.
  localparam logic [CountWidth-1:0] PosCla = 9'd0;
  localparam logic [CountWidth-1:0] PosIns = 9'd1;
  localparam logic [CountWidth-1:0] PosP1 = 9'd2;
  localparam logic [CountWidth-1:0] PosP2 = 9'd3;
  localparam logic [CountWidth-1:0] PosFifth = 9'd4;

  // Block lengths that select the short APDU case.
  localparam logic [CountWidth:0] LenHeaderOnly = 10'd4;
  localparam logic [CountWidth:0] LenWithLe = 10'd5;
  localparam logic [CountWidth:0] LenLcOffset = 10'd5;
  localparam logic [CountWidth:0] LenLcLeOffset = 10'd6;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_OK           = 1'b0,
    STATUS_WRONG_LENGTH = 1'b1
  } status_t;

  typedef struct packed {
    logic [7:0] block_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] class_byte;
    logic [7:0] instruction_byte;
    logic [7:0] param_one;
    logic [7:0] param_two;
    logic [7:0] data_length;
    logic [7:0] expected_length;
    logic       expected_present;
    logic       status;
    logic       end_of_run;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/short_apdu_command_parser.sv
// Top level of the short command APDU parser: block decode and result queue.
//
// Usage: command block bytes enter on the in channel (valid/ready), one per
// transfer, with final_byte set on the last byte of a block. The first four
// bytes are latched as CLA, INS, P1 and P2; byte 4 is Le or Lc. Each Lc data
// byte leaves as a data result (kind 0) if 0 < Lc < data_limit, and the final
// byte also produces a summary result (kind 1) with header, Lc, Le, Le flag and
// status. A byte is decoded in the cycle it is accepted and its results are
// written into a four-entry result queue, so out_valid rises in the cycle after
// the transfer. One byte per cycle is sustained while the receiver takes a result
// every cycle; a final byte carrying data puts two results in the queue and the
// queue then drains at one result per cycle.
// in_ready is high while the queue has room for two results, so a stalled
// receiver stops input once more than two results are queued; nothing is dropped.
// data_limit is written via cfg_wr_en/cfg_wr_data; the user must do so only while
// the block is idle, which the block does not enforce. Synchronous reset empties the
// queue, clears the byte counter and header registers and sets data_limit to 256.
`default_nettype none

module short_apdu_command_parser (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire sacp_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output sacp_pkg::out_t                    out_data,
  input  wire                               cfg_wr_en,
  input  wire [sacp_pkg::LimitWidth-1:0]    cfg_wr_data
);
  import sacp_pkg::*;

  logic [LimitWidth-1:0] data_limit;
  logic [CountWidth-1:0] byte_count;
  logic [CountWidth-1:0] byte_count_next;
  logic [7:0] cla_reg, ins_reg, p1_reg, p2_reg, fifth_byte;
  logic [7:0] cla_next, ins_next, p1_next, p2_next, fifth_next;

  out_t queue [QueueDepth];
  logic [QueuePtrWidth-1:0] head, tail, tail_plus;
  logic [QueueCountWidth-1:0] fill;
  logic [QueueCountWidth-1:0] fill_next;

  logic in_xfer, out_xfer;
  logic [7:0] b;
  logic lc_ok, emit_data;
  logic [CountWidth:0] len, data_end, len_lc, len_lc_le;
  logic [1:0] push_count;
  out_t data_res, sum_res, res0, res1;

  assign in_ready  = fill <= QueueCountWidth'(QueueDepth - 2);
  assign out_valid = fill != '0;
  assign out_data  = queue[head];
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign b         = in_data.block_byte;

  // Header capture; the start of a block clears the bytes not yet seen.
  always_comb begin
    cla_next   = cla_reg;
    ins_next   = ins_reg;
    p1_next    = p1_reg;
    p2_next    = p2_reg;
    fifth_next = fifth_byte;
    case (byte_count)
      PosCla: begin
        cla_next   = b;
        ins_next   = '0;
        p1_next    = '0;
        p2_next    = '0;
        fifth_next = '0;
      end
      PosIns:   ins_next = b;
      PosP1:    p1_next = b;
      PosP2:    p2_next = b;
      PosFifth: fifth_next = b;
      default: ;
    endcase
  end

  always_comb begin
    lc_ok     = (fifth_next != '0) && ({1'b0, fifth_next} < data_limit);
    data_end  = (CountWidth+1)'(PosFifth) + (CountWidth+1)'(fifth_next);
    emit_data = (byte_count > PosFifth) && lc_ok && ({1'b0, byte_count} <= data_end);
    len       = {1'b0, byte_count} + 1'b1;
    len_lc    = (CountWidth+1)'(fifth_next) + LenLcOffset;
    len_lc_le = (CountWidth+1)'(fifth_next) + LenLcLeOffset;

    data_res           = '0;
    data_res.kind      = KIND_DATA;
    data_res.data_byte = b;

    sum_res                  = '0;
    sum_res.kind             = KIND_SUMMARY;
    sum_res.class_byte       = cla_next;
    sum_res.instruction_byte = ins_next;
    sum_res.param_one        = p1_next;
    sum_res.param_two        = p2_next;
    sum_res.end_of_run       = 1'b1;
    sum_res.status           = STATUS_WRONG_LENGTH;
    if (len == LenHeaderOnly) begin
      sum_res.status = STATUS_OK;
    end else if (len == LenWithLe) begin
      sum_res.expected_length  = b;
      sum_res.expected_present = 1'b1;
      sum_res.status           = STATUS_OK;
    end else if (len > LenWithLe && fifth_next != '0) begin
      sum_res.data_length = fifth_next;
      if (lc_ok) begin
        if (len == len_lc) begin
          sum_res.status = STATUS_OK;
        end else if (len == len_lc_le) begin
          sum_res.expected_length  = b;
          sum_res.expected_present = 1'b1;
          sum_res.status           = STATUS_OK;
        end
      end
    end

    // A data result always goes ahead of the summary of the same byte.
    res0       = emit_data ? data_res : sum_res;
    res1       = sum_res;
    push_count = {1'b0, emit_data} + {1'b0, in_data.final_byte};
    if (!in_xfer) begin
      push_count = '0;
    end
  end

  always_comb begin
    byte_count_next = byte_count;
    if (in_data.final_byte) begin
      byte_count_next = '0;
    end else if (byte_count != CountMax) begin
      byte_count_next = byte_count + 1'b1;
    end
  end

  assign tail_plus = tail + 1'b1;
  assign fill_next = fill + QueueCountWidth'(push_count) - QueueCountWidth'(out_xfer);

  always_ff @(posedge clk) begin
    if (rst) begin
      data_limit <= LimitReset;
      byte_count <= '0;
      cla_reg    <= '0;
      ins_reg    <= '0;
      p1_reg     <= '0;
      p2_reg     <= '0;
      fifth_byte <= '0;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
    end else begin
      if (cfg_wr_en) begin
        data_limit <= cfg_wr_data;
      end
      if (in_xfer) begin
        byte_count <= byte_count_next;
        cla_reg    <= cla_next;
        ins_reg    <= ins_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        fifth_byte <= fifth_next;
        tail       <= tail + QueuePtrWidth'(push_count);
      end
      if (out_xfer) begin
        head <= head + 1'b1;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != '0) begin
      queue[tail] <= res0;
    end
    if (push_count == 2'd2) begin
      queue[tail_plus] <= res1;
    end
  end

endmodule

`default_nettype wire
